// ===== design/edm_pkg.sv =====
// ---------------------------------------------------------------------------
// edm_pkg: shared types and constants for the enqueue/dequeue matcher
// Beat types, status codes, controller states and the pending-cell control.
// ---------------------------------------------------------------------------
`default_nettype none

package edm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_W        = 48;
    localparam int TAG_W       = 16;
    localparam int LVL_N       = $clog2(TABLE_DEPTH);

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_MATCHED   = 2'd1,
        ST_UNMATCHED = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    typedef struct packed {
        t_opcode           opcode;
        logic [ID_W-1:0]   queue_id;
        logic [ID_W-1:0]   item_value;
        logic [TAG_W-1:0]  event_tag;
    } t_in_beat;

    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  matched_tag;
    } t_out_beat;

    // One pending entry as it moves between neighbor cells
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   qid;
        logic [ID_W-1:0]   item;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic cmp;   // latch key compare
        logic push;  // take entry from newer neighbor
        logic pull;  // take entry from older neighbor
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/enqueue_dequeue_matcher_core.sv =====
// ---------------------------------------------------------------------------
// enqueue_dequeue_matcher_core: pairs dequeue events with pending enqueues
// Chain of pending cells, newest entry in cell 0. A dequeue consumes the
// newest matching entry and closes the gap; enqueues push at the young end.
// ---------------------------------------------------------------------------
//  channel  dir  handshake                 beat
//  in       in   i_in_valid / o_in_stall   t_in_beat  (opcode, ids, tag)
//  out      out  o_out_valid / i_out_stall t_out_beat (status, matched tag)
//
//  Each event runs capture, compare in every cell, then update chain.
//  The next event is taken after the update; a waiting result does not block
//  capture and compare, only the update, which holds until the output frees.
//  Reset empties the table at once (valid bit per cell), no clearing pass.
//  One result beat per event, in event order.
// ---------------------------------------------------------------------------
`default_nettype none

module enqueue_dequeue_matcher_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  edm_pkg::t_in_beat     i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output edm_pkg::t_out_beat    o_out_data,
    input  wire                   i_out_stall
);

    localparam int D = edm_pkg::TABLE_DEPTH;

    edm_pkg::t_state    r_state, n_state;
    edm_pkg::t_in_beat  r_evt;
    logic               r_out_valid;
    edm_pkg::t_out_beat r_out, n_out;

    edm_pkg::t_entry    w_ent  [D];
    edm_pkg::t_cell_ctl w_ctl  [D];
    logic [D-1:0]       w_hit;
    logic [D-1:0]       w_vld;
    logic [D-1:0]       w_sel;
    logic [D-1:0]       w_first;
    logic [edm_pkg::TAG_W-1:0] w_tag;
    logic               w_adv;
    logic               w_room;
    logic               w_full;
    logic               w_any;
    logic               w_deq;
    edm_pkg::t_entry    w_new;

    // ---------------- cell chain ----------------
    assign w_new.valid = 1'b1;
    assign w_new.qid   = r_evt.queue_id;
    assign w_new.item  = r_evt.item_value;
    assign w_new.tag   = r_evt.event_tag;

    for (genvar j = 0; j < D; j++) begin : g_cell
        edm_pkg::t_entry w_newer, w_older;
        if (j == 0) begin : g_head
            assign w_newer = w_new;
        end else begin : g_mid
            assign w_newer = w_ent[j-1];
        end
        if (j == D-1) begin : g_tail
            assign w_older = '0;
        end else begin : g_body
            assign w_older = w_ent[j+1];
        end

        edm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[j]),
            .i_key_qid  (r_evt.queue_id),
            .i_key_item (r_evt.item_value),
            .i_newer    (w_newer),
            .i_older    (w_older),
            .o_entry    (w_ent[j]),
            .o_hit      (w_hit[j])
        );
        assign w_vld[j] = w_ent[j].valid;
    end

    // ---------------- match select ----------------
    // w_sel[j]: some cell at or newer than j matched; those cells pull down.
    always_comb begin
        w_sel = w_hit;
        for (int l = 0; l < edm_pkg::LVL_N; l++) begin
            w_sel = w_sel | (w_sel << (1 << l));
        end
        w_first = w_sel & ~(w_sel << 1);
        w_tag   = '0;
        for (int j = 0; j < D; j++) begin
            w_tag = w_tag | (w_ent[j].tag & {edm_pkg::TAG_W{w_first[j]}});
        end
    end

    assign w_any  = w_sel[D-1];
    assign w_full = w_vld[D-1];
    assign w_deq  = (r_evt.opcode == edm_pkg::OP_DEQ);
    assign w_room = !r_out_valid || !i_out_stall;
    assign w_adv  = (r_state == edm_pkg::S_UPD) && w_room;

    always_comb begin
        for (int j = 0; j < D; j++) begin
            w_ctl[j].cmp  = (r_state == edm_pkg::S_CMP);
            w_ctl[j].push = w_adv && !w_deq && !w_full;
            w_ctl[j].pull = w_adv && w_deq && w_sel[j];
        end
    end

    // ---------------- controller ----------------
    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        case (r_state)
            edm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = edm_pkg::S_CMP;
            end
            edm_pkg::S_CMP: begin
                n_state = edm_pkg::S_UPD;
            end
            edm_pkg::S_UPD: begin
                if (w_room) begin
                    n_state           = edm_pkg::S_IDLE;
                    n_out.matched_tag = '0;
                    if (!w_deq) begin
                        n_out.status = w_full ? edm_pkg::ST_FULL : edm_pkg::ST_STORED;
                    end else if (w_any) begin
                        n_out.status      = edm_pkg::ST_MATCHED;
                        n_out.matched_tag = w_tag;
                    end else begin
                        n_out.status = edm_pkg::ST_UNMATCHED;
                    end
                end
            end
            default: n_state = edm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == edm_pkg::S_IDLE && i_in_valid) begin
            r_evt <= i_in_data;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != edm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    // table stays packed toward cell 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld >> 1) & ~w_vld) == '0)
        else $error("pending table has a gap");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != edm_pkg::ST_MATCHED)
            |-> (o_out_data.matched_tag == '0))
        else $error("tag on non-matched result");

    a_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_deq && w_any)
            |=> ($countones(w_vld) == $countones($past(w_vld)) - 1))
        else $error("matched dequeue did not remove exactly one entry");

    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_deq && !w_full)
            |=> ($countones(w_vld) == $countones($past(w_vld)) + 1))
        else $error("stored enqueue did not add one entry");

endmodule

`default_nettype wire

// ===== design/edm_cell.sv =====
// ---------------------------------------------------------------------------
// edm_cell: one slot of the pending table
// Holds an entry, compares it with the broadcast key and moves it to or
// from its neighbors when the table shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module edm_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  edm_pkg::t_cell_ctl           i_ctl,
    input  wire  [edm_pkg::ID_W-1:0]     i_key_qid,
    input  wire  [edm_pkg::ID_W-1:0]     i_key_item,
    input  edm_pkg::t_entry              i_newer,
    input  edm_pkg::t_entry              i_older,
    output edm_pkg::t_entry              o_entry,
    output logic                         o_hit
);

    edm_pkg::t_entry r_ent, n_ent;
    logic            r_hit, n_hit;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.push) begin
            n_ent = i_newer;
        end else if (i_ctl.pull) begin
            n_ent = i_older;
        end
        n_hit = r_hit;
        if (i_ctl.cmp) begin
            n_hit = r_ent.valid && (r_ent.qid == i_key_qid) && (r_ent.item == i_key_item);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
            r_hit       <= n_hit;
        end
        r_ent.qid  <= n_ent.qid;
        r_ent.item <= n_ent.item;
        r_ent.tag  <= n_ent.tag;
    end

    assign o_entry = r_ent;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire
